### sv/btlv_pkg.sv
// shared types, codes and constants of the ber tlv header parser
package btlv_pkg;

  // most length octets accepted in the long form
  localparam int MaxLengthOctets = 8;

  // parser phases
  localparam logic [2:0] PH_TAG        = 3'd0;
  localparam logic [2:0] PH_LEN        = 3'd1;
  localparam logic [2:0] PH_OCTETS     = 3'd2;
  localparam logic [2:0] PH_BITS_DEF   = 3'd3;
  localparam logic [2:0] PH_BITS_INDEF = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TAG       = 3'd1;
  localparam logic [2:0] ST_INDEF     = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;
  localparam logic [2:0] ST_EMPTY_BITS = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_EXPECTED_TAG      = 3'd0;
  localparam logic [2:0] CFG_ANY_TAG_MODE      = 3'd1;
  localparam logic [2:0] CFG_LENGTH_MODE       = 3'd2;
  localparam logic [2:0] CFG_BIT_STRING_MODE   = 3'd3;
  localparam logic [2:0] CFG_LONG_LENGTH_LIMIT = 3'd4;

  // configuration reset values
  localparam logic [7:0]  RstExpectedTag    = 8'h30;
  localparam logic [30:0] RstLongLengthLimit = 31'd2146435071;

  // universal tags accepted in any-tag mode
  localparam logic [7:0] TAG_BIT_STRING     = 8'h03;
  localparam logic [7:0] TAG_OCTET_STRING   = 8'h04;
  localparam logic [7:0] TAG_OCTET_STRING_C = 8'h24;
  localparam logic [7:0] TAG_SEQUENCE       = 8'h30;
  localparam logic [7:0] TAG_SET            = 8'h31;

  typedef struct packed {
    logic [7:0]  expected_tag;
    logic        any_tag_mode;
    logic [1:0]  length_mode;
    logic        bit_string_mode;
    logic [30:0] long_length_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] decoded_length;
    logic        is_indefinite;
    logic [7:0]  tag_seen;
  } result_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  held_tag;
    logic [3:0]  octets_left;
    logic [2:0]  significant_count;
    logic [31:0] length_accum;
    logic        error_pending;
  } parse_state_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_out_t;

endpackage

### sv/btlv_step.sv
// one-octet step of the header parser: next state and optional result
module btlv_step (
  input  btlv_pkg::cfg_t         cfg,
  input  btlv_pkg::parse_state_t state,
  input  btlv_pkg::byte_t        item,
  output btlv_pkg::parse_state_t state_next,
  output btlv_pkg::step_out_t    step
);

  logic [7:0]  b;
  logic [2:0]  ph;
  logic [2:0]  cap;
  logic        do_def;
  logic [31:0] def_len;
  logic        tag_ok;

  assign b = item.data_byte;

  // tag check against expected tag or the permitted set
  always_comb begin
    if (!cfg.any_tag_mode) begin
      tag_ok = (b == cfg.expected_tag);
    end else begin
      tag_ok = (b[7:6] == 2'b10) || (b == btlv_pkg::TAG_BIT_STRING) ||
               (b == btlv_pkg::TAG_OCTET_STRING) || (b == btlv_pkg::TAG_OCTET_STRING_C) ||
               (b == btlv_pkg::TAG_SEQUENCE) || (b == btlv_pkg::TAG_SET);
    end
  end

  // phase decode and state update
  always_comb begin
    state_next              = state;
    step.emit               = 1'b0;
    step.res.status         = btlv_pkg::ST_OK;
    step.res.decoded_length = '0;
    step.res.is_indefinite  = 1'b0;
    step.res.tag_seen       = state.held_tag;
    do_def                  = 1'b0;
    def_len                 = '0;
    cap                     = cfg.length_mode[1] ? 3'd4 : 3'd2;
    ph                      = item.frame_start ? btlv_pkg::PH_TAG : state.phase;

    unique case (ph)
      btlv_pkg::PH_LEN: begin
        if (!b[7]) begin
          do_def  = 1'b1;
          def_len = {25'd0, b[6:0]};
        end else if (b[6:0] == 7'd0) begin
          if (cfg.length_mode == 2'd0) begin
            step.emit       = 1'b1;
            step.res.status = btlv_pkg::ST_INDEF;
          end else if (cfg.bit_string_mode) begin
            state_next.phase = btlv_pkg::PH_BITS_INDEF;
          end else begin
            step.emit              = 1'b1;
            step.res.is_indefinite = 1'b1;
          end
        end else if (b[6:0] > 7'(btlv_pkg::MaxLengthOctets)) begin
          step.emit       = 1'b1;
          step.res.status = btlv_pkg::ST_MALFORMED;
        end else begin
          state_next.octets_left       = b[3:0];
          state_next.significant_count = '0;
          state_next.length_accum      = '0;
          state_next.error_pending     = 1'b0;
          state_next.phase             = btlv_pkg::PH_OCTETS;
        end
      end
      btlv_pkg::PH_OCTETS: begin
        // skip leading zeros, cap significant octets
        if (!state.error_pending && !(state.significant_count == 3'd0 && b == 8'd0)) begin
          if (state.significant_count >= cap) begin
            state_next.error_pending = 1'b1;
          end else begin
            state_next.significant_count = state.significant_count + 3'd1;
            state_next.length_accum      = {state.length_accum[23:0], b};
          end
        end
        state_next.octets_left = state.octets_left - 4'd1;
        if (state_next.octets_left == 4'd0) begin
          if (state_next.error_pending) begin
            step.emit       = 1'b1;
            step.res.status = btlv_pkg::ST_MALFORMED;
          end else if (cfg.length_mode[1]) begin
            if (state_next.length_accum[31] ||
                (state_next.length_accum[30:0] > cfg.long_length_limit)) begin
              step.emit       = 1'b1;
              step.res.status = btlv_pkg::ST_LIMIT;
            end else begin
              do_def  = 1'b1;
              def_len = state_next.length_accum;
            end
          end else if (state_next.length_accum[31:15] != 17'd0) begin
            step.emit       = 1'b1;
            step.res.status = btlv_pkg::ST_LIMIT;
          end else begin
            do_def  = 1'b1;
            def_len = state_next.length_accum;
          end
        end
      end
      btlv_pkg::PH_BITS_DEF: begin
        step.emit               = 1'b1;
        step.res.decoded_length = state.length_accum[30:0];
      end
      btlv_pkg::PH_BITS_INDEF: begin
        step.emit              = 1'b1;
        step.res.is_indefinite = 1'b1;
      end
      default: begin
        state_next.held_tag = b;
        step.res.tag_seen   = b;
        if (!tag_ok) begin
          step.emit       = 1'b1;
          step.res.status = btlv_pkg::ST_TAG;
        end else begin
          state_next.phase = btlv_pkg::PH_LEN;
        end
      end
    endcase

    // definite length known: bit-string step, or the result directly
    if (do_def) begin
      if (cfg.bit_string_mode) begin
        if (def_len == 32'd0) begin
          step.emit       = 1'b1;
          step.res.status = btlv_pkg::ST_EMPTY_BITS;
        end else begin
          state_next.length_accum = def_len - 32'd1;
          state_next.phase        = btlv_pkg::PH_BITS_DEF;
        end
      end else begin
        step.emit               = 1'b1;
        step.res.decoded_length = def_len[30:0];
      end
    end

    if (step.emit) begin
      state_next.phase = btlv_pkg::PH_TAG;
    end
  end

endmodule

### sv/ber_tlv_header_parser_unit.sv
// ber tlv header parser: one octet per cycle unless stalled, one result per header
// an accepted octet is registered, decoded by the step logic once the result register is
// free, and its result (if any) is held in the result register
// throughput is one octet per cycle while results are not stalled, set by the combinational step logic
// while a result waits under stall, the input register still takes one more octet
// reset clears the parse state, the pipeline and restores register reset values
module ber_tlv_header_parser_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  btlv_pkg::byte_t   byte_item,
  output logic              result_valid,
  input  logic              result_stall,
  output btlv_pkg::result_t result_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  btlv_pkg::cfg_t         cfg;
  btlv_pkg::parse_state_t state;
  btlv_pkg::parse_state_t state_next;
  btlv_pkg::step_out_t    step;
  btlv_pkg::byte_t        s1_item;
  logic                   s1_valid;
  logic                   out_free;
  logic                   step_go;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_tag      <= btlv_pkg::RstExpectedTag;
      cfg.any_tag_mode      <= 1'b0;
      cfg.length_mode       <= 2'd0;
      cfg.bit_string_mode   <= 1'b0;
      cfg.long_length_limit <= btlv_pkg::RstLongLengthLimit;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btlv_pkg::CFG_EXPECTED_TAG:      cfg.expected_tag      <= cfg_data[7:0];
        btlv_pkg::CFG_ANY_TAG_MODE:      cfg.any_tag_mode      <= cfg_data[0];
        btlv_pkg::CFG_LENGTH_MODE:       cfg.length_mode       <= cfg_data[1:0];
        btlv_pkg::CFG_BIT_STRING_MODE:   cfg.bit_string_mode   <= cfg_data[0];
        btlv_pkg::CFG_LONG_LENGTH_LIMIT: cfg.long_length_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // handshake: the step runs whenever an octet is registered and the result register can take its output
  assign out_free   = !result_valid || !result_stall;
  assign step_go    = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_item;
    end
  end

  btlv_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .step       (step)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step_go) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step_go && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && step.emit) begin
      result_item <= step.res;
    end
  end

endmodule

### sv/btlv_checker.sv
// port-level checks of the header parser result channel, bound to the top level
module btlv_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input btlv_pkg::result_t result_item
);

  // a stalled result transaction stays and holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // no result in the cycle after reset
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result_valid)
    else $error("result right after reset");

  // status stays within the defined codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.status <= btlv_pkg::ST_EMPTY_BITS))
    else $error("undefined status code");

  // an error carries no length and no indefinite flag
  a_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.status != btlv_pkg::ST_OK) |->
      (result_item.decoded_length == 31'd0) && !result_item.is_indefinite)
    else $error("error result with length");

  // indefinite length reports zero
  a_indef: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.is_indefinite |-> (result_item.decoded_length == 31'd0))
    else $error("indefinite result with length");

endmodule

bind ber_tlv_header_parser_unit btlv_checker u_btlv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
